// ===== sv/cbp_pkg.sv =====
package cbp_pkg;

    localparam int ADDR_W = 32;
    localparam int COUNT_W = 32;
    localparam int HIST_CFG_W = 3;
    localparam int CTR_W = 2;

    localparam logic [HIST_CFG_W-1:0] HIST_CFG_RESET = 3'd2;

    typedef enum logic [CTR_W-1:0] {
        CTR_STRONG_NOT_TAKEN = 2'd0,
        CTR_WEAK_NOT_TAKEN   = 2'd1,
        CTR_WEAK_TAKEN       = 2'd2,
        CTR_STRONG_TAKEN     = 2'd3
    } ctr_t;

    typedef struct packed {
        logic valid;
        logic mispredict;
    } cbp_event_t;

    function automatic ctr_t next_counter(input ctr_t cur, input logic tk);
        ctr_t nxt;
        if (!tk)
        begin
            nxt = (cur == CTR_STRONG_TAKEN) ? CTR_WEAK_TAKEN : CTR_STRONG_NOT_TAKEN;
        end
        else
        begin
            nxt = (cur == CTR_STRONG_NOT_TAKEN) ? CTR_WEAK_NOT_TAKEN : CTR_STRONG_TAKEN;
        end
        return nxt;
    endfunction

    function automatic logic predicts_taken(input ctr_t cur);
        return (cur == CTR_WEAK_TAKEN) || (cur == CTR_STRONG_TAKEN);
    endfunction

endpackage

// ===== sv/cbp_index.sv =====
module cbp_index #(
    parameter int INDEX_BITS = 12,
    parameter int MAX_HISTORY = 7
) (
    input  logic [cbp_pkg::HIST_CFG_W-1:0] history_bits,
    input  logic [MAX_HISTORY-1:0]         history,
    input  logic [cbp_pkg::ADDR_W-1:0]     branch_address,
    output logic [INDEX_BITS-1:0]          index
);
    import cbp_pkg::*;

    localparam int HCAP_A = (MAX_HISTORY < INDEX_BITS) ? MAX_HISTORY : INDEX_BITS;
    localparam int HCAP_I = (HCAP_A < 7) ? HCAP_A : 7;
    localparam logic [HIST_CFG_W-1:0] HCAP = HIST_CFG_W'(HCAP_I);
    localparam int ABW = $clog2(INDEX_BITS + 1);
    localparam int EXT_W = INDEX_BITS + MAX_HISTORY;

    logic [HIST_CFG_W-1:0] h_eff;
    logic [ABW-1:0]        abits;
    logic [INDEX_BITS-1:0] amask;
    logic [EXT_W-1:0]      hist_shifted;

    always_comb
    begin
        h_eff = history_bits;
        if (int'(history_bits) > HCAP_I)
        begin
            h_eff = HCAP;
        end
        abits = ABW'(INDEX_BITS) - ABW'(h_eff);
        amask = ~({INDEX_BITS{1'b1}} << abits);
        hist_shifted = EXT_W'(history) << abits;
        index = (branch_address[INDEX_BITS-1:0] & amask) | hist_shifted[INDEX_BITS-1:0];
    end

endmodule

// ===== sv/cbp_table.sv =====
module cbp_table #(
    parameter int INDEX_BITS = 12
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [INDEX_BITS-1:0] wr_addr,
    input  cbp_pkg::ctr_t         wr_data,
    input  logic                  rd_en,
    input  logic [INDEX_BITS-1:0] rd_addr,
    output cbp_pkg::ctr_t         rd_data
);
    import cbp_pkg::*;

    localparam int DEPTH = 1 << INDEX_BITS;

    ctr_t mem [DEPTH];
    ctr_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/cbp_stats.sv =====
module cbp_stats (
    input  logic                           clk,
    input  logic                           rst_n,
    input  cbp_pkg::cbp_event_t            ev,
    output logic [cbp_pkg::COUNT_W-1:0]    branch_total,
    output logic [cbp_pkg::COUNT_W-1:0]    mispredict_total
);
    import cbp_pkg::*;

    logic [COUNT_W-1:0] branch_cnt_reg;
    logic [COUNT_W-1:0] branch_cnt_next;
    logic [COUNT_W-1:0] mispred_cnt_reg;
    logic [COUNT_W-1:0] mispred_cnt_next;

    always_comb
    begin
        branch_cnt_next = branch_cnt_reg;
        mispred_cnt_next = mispred_cnt_reg;
        if (ev.valid)
        begin
            if (branch_cnt_reg != {COUNT_W{1'b1}})
            begin
                branch_cnt_next = branch_cnt_reg + COUNT_W'(1);
            end
            if (ev.mispredict && (mispred_cnt_reg != {COUNT_W{1'b1}}))
            begin
                mispred_cnt_next = mispred_cnt_reg + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            branch_cnt_reg <= '0;
            mispred_cnt_reg <= '0;
        end
        else
        begin
            branch_cnt_reg <= branch_cnt_next;
            mispred_cnt_reg <= mispred_cnt_next;
        end
    end

    assign branch_total = branch_cnt_reg;
    assign mispredict_total = mispred_cnt_reg;

endmodule

// ===== sv/correlating_branch_predictor.sv =====
// Channel   Signals                                     Direction  Handshake
// branch    branch_address, taken                       in         br_valid / br_stall
// result    predicted_taken, correct, branch_total,     out        res_valid / res_stall
//           mispredict_total
// config    cfg_data (history_bits)                     in         cfg_valid / cfg_ready
//
// One branch transaction is accepted per cycle unless stalled; its result is registered after the read stage.
// The counter table is a single memory with one read and one write port; the counter
// is read in the cycle of acceptance and written back as the transaction leaves the read stage.
// After reset all 2**INDEX_BITS table entries are cleared, one entry a cycle, and
// br_stall is held high while this goes on. Configuration writes are always accepted.
// A stalled result holds one further transaction in the read stage before br_stall rises.
module correlating_branch_predictor #(
    parameter int INDEX_BITS = 12,
    parameter int MAX_HISTORY = 7
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              br_valid,
    output logic                              br_stall,
    input  logic [cbp_pkg::ADDR_W-1:0]        branch_address,
    input  logic                              taken,
    output logic                              res_valid,
    input  logic                              res_stall,
    output logic                              predicted_taken,
    output logic                              correct,
    output logic [cbp_pkg::COUNT_W-1:0]       branch_total,
    output logic [cbp_pkg::COUNT_W-1:0]       mispredict_total,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cbp_pkg::HIST_CFG_W-1:0]    cfg_data
);
    import cbp_pkg::*;

    logic [HIST_CFG_W-1:0]  hist_cfg_reg;
    logic [MAX_HISTORY-1:0] history_reg;
    logic                   clearing_reg;
    logic [INDEX_BITS-1:0]  clr_idx_reg;

    logic                   s1_valid_reg;
    logic [INDEX_BITS-1:0]  s1_idx_reg;
    logic                   s1_taken_reg;

    logic                   wr_valid_reg;
    logic [INDEX_BITS-1:0]  wr_idx_reg;
    ctr_t                   wr_ctr_reg;

    logic                   res_valid_reg;
    logic                   pred_reg;
    logic                   correct_reg;

    logic [INDEX_BITS-1:0]  in_idx;
    logic                   accept;
    logic                   advance;
    ctr_t                   rd_ctr;
    ctr_t                   cur_ctr;
    ctr_t                   new_ctr;
    logic                   pred;
    logic                   ok;
    logic                   tbl_wr_en;
    logic [INDEX_BITS-1:0]  tbl_wr_addr;
    ctr_t                   tbl_wr_data;
    cbp_event_t             stat_ev;

    cbp_index #(
        .INDEX_BITS  (INDEX_BITS),
        .MAX_HISTORY (MAX_HISTORY)
    ) u_index (
        .history_bits   (hist_cfg_reg),
        .history        (history_reg),
        .branch_address (branch_address),
        .index          (in_idx)
    );

    assign advance = s1_valid_reg && (!res_valid_reg || !res_stall);
    assign br_stall = clearing_reg || (s1_valid_reg && !advance);
    assign accept = br_valid && !br_stall;
    assign cfg_ready = 1'b1;

    // The write made as the current item entered the read stage is not yet visible
    // in the registered read data, so it is forwarded here.
    always_comb
    begin
        cur_ctr = rd_ctr;
        if (wr_valid_reg && (wr_idx_reg == s1_idx_reg))
        begin
            cur_ctr = wr_ctr_reg;
        end
        pred = predicts_taken(cur_ctr);
        new_ctr = next_counter(cur_ctr, s1_taken_reg);
        ok = (pred == s1_taken_reg);
    end

    always_comb
    begin
        tbl_wr_en = clearing_reg || advance;
        tbl_wr_addr = clearing_reg ? clr_idx_reg : s1_idx_reg;
        tbl_wr_data = clearing_reg ? CTR_STRONG_NOT_TAKEN : new_ctr;
    end

    cbp_table #(
        .INDEX_BITS (INDEX_BITS)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_en   (accept),
        .rd_addr (in_idx),
        .rd_data (rd_ctr)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_cfg_reg <= HIST_CFG_RESET;
            history_reg <= '0;
            clearing_reg <= 1'b1;
            clr_idx_reg <= '0;
            s1_valid_reg <= 1'b0;
            wr_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                hist_cfg_reg <= cfg_data;
            end
            if (clearing_reg)
            begin
                clr_idx_reg <= clr_idx_reg + INDEX_BITS'(1);
                if (clr_idx_reg == {INDEX_BITS{1'b1}})
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (accept)
            begin
                history_reg <= MAX_HISTORY'({history_reg, taken});
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                wr_valid_reg <= 1'b1;
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_idx_reg <= in_idx;
            s1_taken_reg <= taken;
        end
        if (advance)
        begin
            wr_idx_reg <= s1_idx_reg;
            wr_ctr_reg <= new_ctr;
            pred_reg <= pred;
            correct_reg <= ok;
        end
    end

    assign stat_ev.valid = advance;
    assign stat_ev.mispredict = !ok;

    cbp_stats u_stats (
        .clk              (clk),
        .rst_n            (rst_n),
        .ev               (stat_ev),
        .branch_total     (branch_total),
        .mispredict_total (mispredict_total)
    );

    assign res_valid = res_valid_reg;
    assign predicted_taken = pred_reg;
    assign correct = correct_reg;

    a_no_work_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> (!s1_valid_reg && !res_valid_reg))
        else $error("transaction in flight while the table is being cleared");

    a_held_item_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance && !clearing_reg) |-> !tbl_wr_en)
        else $error("table written while the read stage is held");

    a_totals_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        mispredict_total <= branch_total)
        else $error("misprediction total exceeds branch total");

    a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (branch_total >= $past(branch_total)))
        else $error("branch total decreased");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    import cbp_pkg::*;

    localparam int INDEX_W = 12;
    localparam int TABLE_DEPTH = 1 << INDEX_W;
    localparam int HIST_W = 7;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic              tk;
    } branch_t;

    typedef struct {
        logic               pred;
        logic               ok;
        logic [COUNT_W-1:0] branches;
        logic [COUNT_W-1:0] misses;
    } outcome_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  br_valid = 1'b0;
    logic                  br_stall;
    logic [ADDR_W-1:0]     branch_address = '0;
    logic                  taken = 1'b0;
    logic                  res_valid;
    logic                  res_stall = 1'b0;
    logic                  predicted_taken;
    logic                  correct;
    logic [COUNT_W-1:0]    branch_total;
    logic [COUNT_W-1:0]    mispredict_total;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [HIST_CFG_W-1:0] cfg_data = '0;

    branch_t  pending_branches[$];
    outcome_t due_outcomes[$];

    ctr_t                  ctr_table [TABLE_DEPTH];
    logic [HIST_W-1:0]     ghist;
    logic [HIST_CFG_W-1:0] hist_len;
    logic [COUNT_W-1:0]    branch_count;
    logic [COUNT_W-1:0]    miss_count;

    logic          eager = 1'b0;
    logic          hold_start = 1'b0;
    int            hold_left;
    int            gap_left;
    int            stall_left;
    int            error_count = 0;
    int            cycle_count = 0;

    logic [ADDR_W-1:0] loop_addr [8];
    int                loop_period [8];
    int                loop_iter [8];

    correlating_branch_predictor u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .br_valid         (br_valid),
        .br_stall         (br_stall),
        .branch_address   (branch_address),
        .taken            (taken),
        .res_valid        (res_valid),
        .res_stall        (res_stall),
        .predicted_taken  (predicted_taken),
        .correct          (correct),
        .branch_total     (branch_total),
        .mispredict_total (mispredict_total),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    task automatic note_failure(input string msg);
        $display("%0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic void resolve_branch(input logic [ADDR_W-1:0] addr, input logic tk);
        int unsigned     abits;
        logic [INDEX_W-1:0] idx;
        ctr_t            cur;
        outcome_t        o;
        abits = INDEX_W - hist_len;
        idx = (addr[INDEX_W-1:0] & ((12'd1 << abits) - 12'd1))
            | ((12'(ghist) & ((12'd1 << hist_len) - 12'd1)) << abits);
        cur = ctr_table[idx];
        o.pred = (cur == CTR_WEAK_TAKEN) || (cur == CTR_STRONG_TAKEN);
        if (tk)
        begin
            ctr_table[idx] = (cur == CTR_STRONG_NOT_TAKEN) ? CTR_WEAK_NOT_TAKEN
                                                            : CTR_STRONG_TAKEN;
        end
        else
        begin
            ctr_table[idx] = (cur == CTR_STRONG_TAKEN) ? CTR_WEAK_TAKEN
                                                        : CTR_STRONG_NOT_TAKEN;
        end
        ghist = {ghist[HIST_W-2:0], tk};
        o.ok = (o.pred == tk);
        if (branch_count != '1)
        begin
            branch_count++;
        end
        if (!o.ok && miss_count != '1)
        begin
            miss_count++;
        end
        o.branches = branch_count;
        o.misses = miss_count;
        due_outcomes.push_back(o);
    endfunction

    function automatic void add_branch(input logic [ADDR_W-1:0] addr, input logic tk);
        branch_t b;
        b.addr = addr;
        b.tk = tk;
        pending_branches.push_back(b);
    endfunction

    // Driver: holds a stalled transaction, otherwise waits out its gap and presents the next.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            br_valid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin : drive_branches
            branch_t b;
            if (br_valid && !br_stall)
            begin
                resolve_branch(branch_address, taken);
            end
            if (br_valid && br_stall)
            begin
                br_valid <= 1'b1;
            end
            else if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                br_valid <= 1'b0;
            end
            else if (pending_branches.size() != 0)
            begin
                b = pending_branches.pop_front();
                branch_address <= b.addr;
                taken <= b.tk;
                br_valid <= 1'b1;
                gap_left <= eager ? 0 : $urandom_range(0, 6);
            end
            else
            begin
                br_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
        end
        else if (hold_start)
        begin
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: checks each accepted result transaction against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
            stall_left <= 0;
        end
        else
        begin : watch_results
            int       next_stall;
            outcome_t o;
            next_stall = stall_left;
            if (res_valid && !res_stall)
            begin
                if (due_outcomes.size() == 0)
                begin
                    note_failure("result transaction with no branch outstanding");
                end
                else
                begin
                    o = due_outcomes.pop_front();
                    if (predicted_taken !== o.pred)
                    begin
                        note_failure($sformatf("predicted_taken %b, expected %b",
                                               predicted_taken, o.pred));
                    end
                    if (correct !== o.ok)
                    begin
                        note_failure($sformatf("correct %b, expected %b", correct, o.ok));
                    end
                    if (branch_total !== o.branches)
                    begin
                        note_failure($sformatf("branch_total %0d, expected %0d",
                                               branch_total, o.branches));
                    end
                    if (mispredict_total !== o.misses)
                    begin
                        note_failure($sformatf("mispredict_total %0d, expected %0d",
                                               mispredict_total, o.misses));
                    end
                end
                next_stall = eager ? 0 : $urandom_range(0, 6);
            end
            else if (stall_left != 0)
            begin
                next_stall = stall_left - 1;
            end
            stall_left <= next_stall;
            res_stall <= (next_stall != 0) || (hold_left != 0);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[correlating_branch_predictor] ERROR");
            $finish;
        end
    end

    task automatic wait_idle();
        while (pending_branches.size() != 0 || br_valid || due_outcomes.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (3) @(posedge clk);
    endtask

    task automatic write_history(input logic [HIST_CFG_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        hist_len = value;
        cfg_valid <= 1'b0;
    endtask

    // Mostly loop-shaped branch streams from a small pool, with some random noise.
    task automatic queue_random_branches(input int n);
        int k;
        logic tk;
        for (int i = 0; i < 8; i++)
        begin
            loop_addr[i] = $urandom();
            loop_period[i] = $urandom_range(1, 5);
            loop_iter[i] = 0;
        end
        @(negedge clk);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                k = $urandom_range(0, 7);
                tk = (loop_iter[k] != loop_period[k]);
                loop_iter[k] = (loop_iter[k] == loop_period[k]) ? 0 : loop_iter[k] + 1;
                if ($urandom_range(0, 15) == 0)
                begin
                    tk = ~tk;
                end
                add_branch(loop_addr[k], tk);
            end
            else
            begin
                add_branch($urandom(), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial
    begin : stimulus
        logic [HIST_CFG_W-1:0] settings [9];
        settings = '{3'd7, 3'd0, 3'd5, 3'd1, 3'd6, 3'd3, 3'd4, 3'd2, 3'd7};
        foreach (ctr_table[i])
        begin
            ctr_table[i] = CTR_STRONG_NOT_TAKEN;
        end
        ghist = '0;
        hist_len = HIST_CFG_RESET;
        branch_count = '0;
        miss_count = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        add_branch(32'h0000_0000, 1'b0);
        add_branch(32'hFFFF_FFFF, 1'b1);
        add_branch(32'hAAAA_AAAA, 1'b1);
        add_branch(32'h5555_5555, 1'b0);
        add_branch(32'h8000_0000, 1'b1);
        add_branch(32'h0000_0FFF, 1'b1);
        add_branch(32'hFFFF_FFFF, 1'b1);
        add_branch(32'hFFFF_FFFF, 1'b1);
        wait_idle();

        // Walk one counter through every state with no history in the index.
        write_history(3'd0);
        @(negedge clk);
        repeat (4) add_branch(32'h0000_1234, 1'b1);
        repeat (3) add_branch(32'h0000_1234, 1'b0);
        add_branch(32'h0000_1234, 1'b1);
        add_branch(32'h0000_1234, 1'b0);
        add_branch(32'h0000_1234, 1'b1);
        add_branch(32'hFFFF_F234, 1'b1);
        add_branch(32'h0000_1234, 1'b0);
        add_branch(32'h0000_1234, 1'b1);
        add_branch(32'h0000_1234, 1'b1);
        wait_idle();

        foreach (settings[p])
        begin
            write_history(settings[p]);
            eager <= (p == 2) || (p == 4);
            if (p == 4)
            begin
                @(negedge clk);
                hold_start = 1'b1;
                @(negedge clk);
                hold_start = 1'b0;
            end
            queue_random_branches(47);
            wait_idle();
        end

        repeat (8) @(posedge clk);
        if (error_count == 0)
        begin
            $display("[correlating_branch_predictor] OK");
        end
        else
        begin
            $display("[correlating_branch_predictor] ERROR");
        end
        $finish;
    end

endmodule
